[sv/lpkv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpkv_pkg: shared types and constants of the linear-probe key/value table
// Operation codes, stream word layout, and the command and status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lpkv_pkg;

  // operation codes carried in s_tuser
  localparam logic [1:0] KIND_GET  = 2'd0;
  localparam logic [1:0] KIND_PUT  = 2'd1;
  localparam logic [1:0] KIND_DEL  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // input word layout
  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 2;
  localparam int KEY_LSB     = 0;
  localparam int LEN_LSB     = 64;
  localparam int VAL_LSB     = 68;
  localparam int IN_VAL_W    = 32;

  // output word layout
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;
  localparam int HIT_BIT     = 0;
  localparam int FULL_BIT    = 1;

  localparam logic [31:0] HASH_MULT = 32'd37;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic mod_start;
    logic mod_step;
    logic probe_init;
    logic advance;
    logic write_put;
    logic write_del;
    logic clear_write;
    logic res_hit;
    logic res_full;
    logic out_load;
  } lpkv_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       hash_done;
    logic       mod_done;
    logic       occ;
    logic       match;
    logic       last_probe;
    logic       clear_last;
  } lpkv_status_t;

endpackage

[sv/lpkv_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpkv_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/lpkv_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpkv_dp: datapath of the linear-probe key/value table
// Item registers, byte-serial hash, iterative slot remainder, probe pointer,
// slot store and the result and output registers.
// ----------------------------------------------------------------------------
module lpkv_dp #(
  parameter int SLOTS      = 64,
  parameter int KEY_BYTES  = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lpkv_pkg::lpkv_cmd_t         cmd,
  output lpkv_pkg::lpkv_status_t      status,
  input  logic [lpkv_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [lpkv_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic [lpkv_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [lpkv_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import lpkv_pkg::*;

  localparam int AW       = $clog2(SLOTS);
  localparam int KW       = 8 * KEY_BYTES;
  localparam int VB       = (VALUE_BITS < IN_VAL_W) ? VALUE_BITS : IN_VAL_W;
  localparam int W        = 1 + 4 + KW + VB;
  localparam bit IS_POW2  = (SLOTS & (SLOTS - 1)) == 0;
  localparam int MOD_STEP = 4;
  localparam int MOD_CYC  = 32 / MOD_STEP;
  localparam logic [3:0]    KB_LEN    = 4'(KEY_BYTES);
  localparam logic [AW:0]   SLOTS_R   = (AW + 1)'(SLOTS);
  localparam logic [AW-1:0] SLOT_LAST = AW'(SLOTS - 1);
  localparam logic [3:0]    MOD_END   = 4'(MOD_CYC);

  logic [1:0]    kind;
  logic [KW-1:0] key;
  logic [KW-1:0] key_sh;
  logic [3:0]    len;
  logic [VB-1:0] val;
  logic [31:0]   h;
  logic [3:0]    bcnt;
  logic [31:0]   h_sh;
  logic [AW:0]   r;
  logic [AW:0]   r_next;
  logic [3:0]    mcnt;
  logic [31:0]   p;
  logic [AW-1:0] idx;
  logic [AW-1:0] pcnt;
  logic [AW-1:0] clr_idx;
  logic          res_hit;
  logic [VB-1:0] res_val;
  logic          res_full;
  logic          out_hit;
  logic [VB-1:0] out_val;
  logic          out_full;

  logic [3:0]    in_len;
  logic [3:0]    len_sat;
  logic [63:0]   in_key;
  logic [KW-1:0] key_m;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic [W-1:0]  rd;
  logic          rd_occ;
  logic [3:0]    rd_len;
  logic [KW-1:0] rd_key;
  logic [VB-1:0] rd_val;

  assign in_len = in_tdata[LEN_LSB +: 4];
  assign in_key = in_tdata[KEY_LSB +: 64];
  assign len_sat = (in_len > KB_LEN) ? KB_LEN : in_len;

  // drop key bytes past the length
  always_comb begin
    for (int i = 0; i < KEY_BYTES; i++) begin
      key_m[8*i +: 8] = (4'(i) < len_sat) ? in_key[8*i +: 8] : 8'd0;
    end
  end

  // restoring remainder, MOD_STEP quotient bits a cycle
  always_comb begin
    r_next = r;
    for (int j = 0; j < MOD_STEP; j++) begin
      r_next = {r_next[AW-1:0], h_sh[31-j]};
      if (r_next >= SLOTS_R) begin
        r_next = r_next - SLOTS_R;
      end
    end
  end

  assign rd_occ = rd[W-1];
  assign rd_len = rd[W-2 -: 4];
  assign rd_key = rd[VB +: KW];
  assign rd_val = rd[VB-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind     <= in_tuser;
      key      <= key_m;
      key_sh   <= key_m;
      len      <= len_sat;
      val      <= in_tdata[VAL_LSB +: VB];
      h        <= 32'd0;
      bcnt     <= 4'd0;
      res_hit  <= 1'b0;
      res_val  <= '0;
      res_full <= 1'b0;
    end
    if (cmd.hash_step) begin
      h      <= h * HASH_MULT + 32'(key_sh[7:0]);
      key_sh <= key_sh >> 8;
      bcnt   <= bcnt + 4'd1;
    end
    if (cmd.mod_start) begin
      h_sh <= h;
      r    <= '0;
      mcnt <= 4'd0;
    end
    if (cmd.mod_step) begin
      h_sh <= h_sh << MOD_STEP;
      r    <= r_next;
      mcnt <= mcnt + 4'd1;
    end
    if (cmd.probe_init) begin
      idx  <= IS_POW2 ? h[AW-1:0] : r[AW-1:0];
      p    <= h;
      pcnt <= '0;
    end
    if (cmd.advance) begin
      // follow the 32-bit wrap of the probe position as well as the slot wrap
      idx  <= (idx == SLOT_LAST || p == 32'hFFFF_FFFF) ? '0 : idx + 1'b1;
      p    <= p + 32'd1;
      pcnt <= pcnt + 1'b1;
    end
    if (cmd.res_hit) begin
      res_hit <= 1'b1;
      if (kind == KIND_GET) begin
        res_val <= rd_val;
      end
    end
    if (cmd.res_full) begin
      res_full <= 1'b1;
    end
    if (cmd.out_load) begin
      out_hit  <= res_hit;
      out_val  <= res_val;
      out_full <= res_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_write) begin
      clr_idx <= (clr_idx == SLOT_LAST) ? '0 : clr_idx + 1'b1;
    end
  end

  always_comb begin
    ram_we    = cmd.write_put | cmd.write_del | cmd.clear_write;
    ram_waddr = cmd.clear_write ? clr_idx : idx;
    if (cmd.write_put) begin
      ram_wdata = {1'b1, len, key, val};
    end else if (cmd.write_del) begin
      ram_wdata = {1'b0, rd[W-2:0]};
    end else begin
      ram_wdata = '0;
    end
  end

  lpkv_ram #(
    .WIDTH (W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (rd)
  );

  always_comb begin
    status.kind       = kind;
    status.hash_done  = (bcnt == len);
    status.mod_done   = IS_POW2 || (mcnt == MOD_END);
    status.occ        = rd_occ;
    status.match      = rd_occ && (rd_len == len) && (rd_key == key);
    status.last_probe = (pcnt == SLOT_LAST);
    status.clear_last = (clr_idx == SLOT_LAST);
  end

  always_comb begin
    out_tdata           = OUT_TDATA_W'(out_val);
    out_tuser           = '0;
    out_tuser[HIT_BIT]  = out_hit;
    out_tuser[FULL_BIT] = out_full;
  end

endmodule

[sv/lpkv_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpkv_ctrl: controller of the linear-probe key/value table
// Sequences the clearing pass, hash, remainder, probe loop and result
// hand-off, and owns the stream handshake.
// ----------------------------------------------------------------------------
module lpkv_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output lpkv_pkg::lpkv_cmd_t    cmd,
  input  lpkv_pkg::lpkv_status_t status
);
  import lpkv_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_EVAL  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (status.kind == KIND_NONE) begin
          state_next = S_DONE;
        end else if (status.hash_done) begin
          cmd.mod_start = 1'b1;
          state_next    = S_MOD;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_MOD: begin
        if (status.mod_done) begin
          cmd.probe_init = 1'b1;
          state_next     = S_READ;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_DONE;
        if (status.kind == KIND_PUT) begin
          if (!status.occ || status.match) begin
            cmd.write_put = 1'b1;
            cmd.res_hit   = 1'b1;
          end else if (status.last_probe) begin
            cmd.res_full = 1'b1;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_READ;
          end
        end else if (status.occ) begin
          if (status.match) begin
            cmd.res_hit   = 1'b1;
            cmd.write_del = (status.kind == KIND_DEL);
          end else if (!status.last_probe) begin
            cmd.advance = 1'b1;
            state_next  = S_READ;
          end
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result loaded but not presented");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !((cmd.write_put && cmd.write_del) || (cmd.clear_write && cmd.write_put)))
    else $error("conflicting slot writes");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_HASH))
    else $error("accepted word did not start the hash");

  a_write_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.write_put || cmd.write_del) |=> (state == S_DONE))
    else $error("probe continued after a slot write");
`endif

endmodule

[sv/linear_probe_key_value_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_key_value_table_top: open-addressing key/value table
// Lookup, insert-or-update and remove of keys up to eight bytes, with
// linear probing over a slot RAM.
// ----------------------------------------------------------------------------
// One item is taken at a time. The hash takes one key byte per step, with
// key_length capped at KEY_BYTES. When SLOTS is a power of two the low hash
// bits pick the first slot; otherwise the slot remainder is computed
// iteratively. Each probe is a registered read of the slot RAM in S_READ
// followed by a compare in S_EVAL. Kind 3 goes from the hash state straight
// to the result hand-off without probing. s_tready rises in the cycle after
// the result is loaded. After reset the block clears every slot of the slot
// RAM before s_tready first rises. The output register lets the next item be
// accepted while a result waits on m_tready.
// ----------------------------------------------------------------------------
module linear_probe_key_value_table_top #(
  parameter int SLOTS      = 64,
  parameter int KEY_BYTES  = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // key_bytes[63:0], key_length[67:64], value_in[99:68], zero pad[103:100]
  input  logic [lpkv_pkg::IN_TDATA_W-1:0]     s_tdata,
  // kind[1:0]
  input  logic [lpkv_pkg::IN_TUSER_W-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // value_out[31:0]
  output logic [lpkv_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // hit[0], table_full[1]
  output logic [lpkv_pkg::OUT_TUSER_W-1:0]    m_tuser
);
  import lpkv_pkg::*;

  lpkv_cmd_t    cmd;
  lpkv_status_t status;

  lpkv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  lpkv_dp #(
    .SLOTS      (SLOTS),
    .KEY_BYTES  (KEY_BYTES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_tdata  (s_tdata),
    .in_tuser  (s_tuser),
    .out_tdata (m_tdata),
    .out_tuser (m_tuser)
  );

endmodule
